// ===== hdl/egb_pkg.sv =====
// Shared types, micro-op codes and the control program of the extended GCD block.
package egb_pkg;

  // Default coefficient width; operands and the divisor are one bit narrower.
  localparam int unsigned EGB_OPERAND_BITS = 32;

  // Width of the step counter of the sequencer.
  localparam int unsigned PC_BITS = 3;

  // Datapath operations selected by one control word.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_DIV,
    OP_SWAP,
    OP_EMIT
  } egb_op_e;

  // Jump conditions of one control word.
  typedef enum logic [2:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_NO_INPUT,
    CND_R1_ZERO,
    CND_DIV_MORE,
    CND_OUT_BUSY
  } egb_cond_e;

  typedef logic [PC_BITS-1:0] egb_pc_t;

  // Program addresses.
  localparam egb_pc_t STEP_WAIT = egb_pc_t'(0);
  localparam egb_pc_t STEP_TEST = egb_pc_t'(1);
  localparam egb_pc_t STEP_DIV  = egb_pc_t'(2);
  localparam egb_pc_t STEP_SWAP = egb_pc_t'(3);
  localparam egb_pc_t STEP_EMIT = egb_pc_t'(4);

  // One control word: operation, jump condition and jump target.
  typedef struct packed {
    egb_op_e   op;
    egb_cond_e cond;
    egb_pc_t   target;
  } egb_uword_t;

  // Status flags returned by the datapath to the sequencer.
  typedef struct packed {
    logic r1_zero;
    logic div_last;
  } egb_status_t;

  // Control program. A word that does not jump falls through to the next address.
  function automatic egb_uword_t egb_rom(egb_pc_t pc);
    egb_uword_t word;
    case (pc)
      STEP_WAIT: word = '{op: OP_LOAD, cond: CND_NO_INPUT, target: STEP_WAIT};
      STEP_TEST: word = '{op: OP_INIT, cond: CND_R1_ZERO,  target: STEP_EMIT};
      STEP_DIV:  word = '{op: OP_DIV,  cond: CND_DIV_MORE, target: STEP_DIV};
      STEP_SWAP: word = '{op: OP_SWAP, cond: CND_ALWAYS,   target: STEP_TEST};
      STEP_EMIT: word = '{op: OP_EMIT, cond: CND_OUT_BUSY, target: STEP_EMIT};
      default:   word = '{op: OP_NONE, cond: CND_ALWAYS,   target: STEP_WAIT};
    endcase
    return word;
  endfunction

endpackage

// ===== hdl/egb_seq.sv =====
// Microcode sequencer: step counter, control program lookup and conditional jumps.
module egb_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                out_busy_i,
  input  egb_pkg::egb_status_t status_i,
  output egb_pkg::egb_op_e    op_o,
  output logic                load_ready_o
);
  import egb_pkg::*;

  egb_pc_t    pc_q, pc_d;
  egb_uword_t word;
  logic       taken;
  logic       fire;

  assign word = egb_rom(pc_q);

  // Evaluate the jump condition of the current word.
  always_comb begin
    case (word.cond)
      CND_NEVER:    taken = 1'b0;
      CND_ALWAYS:   taken = 1'b1;
      CND_NO_INPUT: taken = !in_valid_i;
      CND_R1_ZERO:  taken = status_i.r1_zero;
      CND_DIV_MORE: taken = !status_i.div_last;
      CND_OUT_BUSY: taken = out_busy_i;
      default:      taken = 1'b0;
    endcase
  end

  // A load needs an input transfer and an emit needs a free output register.
  assign fire = !(word.op == OP_LOAD && !in_valid_i) && !(word.op == OP_EMIT && out_busy_i);
  assign op_o = fire ? word.op : OP_NONE;
  assign load_ready_o = (word.op == OP_LOAD);

  assign pc_d = taken ? word.target : pc_q + egb_pc_t'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ===== hdl/egb_dp.sv =====
// Datapath: remainder and coefficient registers with a bit-serial divide and multiply-accumulate.
module egb_dp #(
  parameter int unsigned OPERAND_BITS = egb_pkg::EGB_OPERAND_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  egb_pkg::egb_op_e         op_i,
  input  logic [OPERAND_BITS-2:0]  operand_a_i,
  input  logic [OPERAND_BITS-2:0]  operand_b_i,
  output egb_pkg::egb_status_t     status_o,
  output logic [OPERAND_BITS-2:0]  divisor_o,
  output logic [OPERAND_BITS-1:0]  coeff_x_o,
  output logic [OPERAND_BITS-1:0]  coeff_y_o
);
  import egb_pkg::*;

  localparam int unsigned W  = OPERAND_BITS - 1;
  localparam int unsigned N  = OPERAND_BITS;
  localparam int unsigned CW = $clog2(W);

  logic [W-1:0]  r0_q, r0_d, r1_q, r1_d;
  logic [N-1:0]  s0_q, s0_d, s1_q, s1_d;
  logic [N-1:0]  t0_q, t0_d, t1_q, t1_d;
  logic [W-1:0]  rem_q, rem_d, dvd_q, dvd_d;
  logic [N-1:0]  acc_s_q, acc_s_d, acc_t_q, acc_t_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          qbit;

  // One restoring division step: bring down the next dividend bit and try to subtract.
  assign trial = {rem_q, dvd_q[W-1]};
  assign diff  = trial - {1'b0, r1_q};
  assign qbit  = (trial >= {1'b0, r1_q});

  always_comb begin
    r0_d    = r0_q;
    r1_d    = r1_q;
    s0_d    = s0_q;
    s1_d    = s1_q;
    t0_d    = t0_q;
    t1_d    = t1_q;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    acc_s_d = acc_s_q;
    acc_t_d = acc_t_q;
    cnt_d   = cnt_q;
    case (op_i)
      OP_LOAD: begin
        r0_d = operand_a_i;
        r1_d = operand_b_i;
        s0_d = N'(1);
        s1_d = '0;
        t0_d = '0;
        t1_d = N'(1);
      end
      OP_INIT: begin
        rem_d   = '0;
        dvd_d   = r0_q;
        acc_s_d = '0;
        acc_t_d = '0;
        cnt_d   = '0;
      end
      OP_DIV: begin
        // Quotient bits arrive MSB first, so the products q*s1 and q*t1 build up by shift-add.
        rem_d   = qbit ? diff[W-1:0] : trial[W-1:0];
        dvd_d   = {dvd_q[W-2:0], 1'b0};
        acc_s_d = {acc_s_q[N-2:0], 1'b0} + (qbit ? s1_q : '0);
        acc_t_d = {acc_t_q[N-2:0], 1'b0} + (qbit ? t1_q : '0);
        cnt_d   = cnt_q + CW'(1);
      end
      OP_SWAP: begin
        r0_d = r1_q;
        r1_d = rem_q;
        s0_d = s1_q;
        s1_d = s0_q - acc_s_q;
        t0_d = t1_q;
        t1_d = t0_q - acc_t_q;
      end
      default: begin
      end
    endcase
  end

  // Step counter of the divide loop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Working registers hold payload only.
  always_ff @(posedge clk_i) begin
    r0_q    <= r0_d;
    r1_q    <= r1_d;
    s0_q    <= s0_d;
    s1_q    <= s1_d;
    t0_q    <= t0_d;
    t1_q    <= t1_d;
    rem_q   <= rem_d;
    dvd_q   <= dvd_d;
    acc_s_q <= acc_s_d;
    acc_t_q <= acc_t_d;
  end

  assign status_o.r1_zero  = (r1_q == '0);
  assign status_o.div_last = (cnt_q == CW'(W - 1));

  assign divisor_o = r0_q;
  assign coeff_x_o = s0_q;
  assign coeff_y_o = t0_q;

endmodule

// ===== hdl/extended_gcd_bezout.sv =====
// Top level of the extended GCD block: sequencer, datapath and result register.
// Computes gcd(a, b) with Bezout coefficients x, y (a*x + b*y = gcd) by the iterative
// Euclidean loop. One item is worked at a time. After the input transfer, every quotient
// step is one test, a bit-serial divide over the OPERAND_BITS - 1 quotient bits and one
// update, and the item ends with one test, one emit and one return step; for 31-bit
// operands an item has at most 45 quotient steps. The bit-serial divider retires one
// quotient bit per cycle. The result sits in an output register, so a new input is
// taken while the previous result still waits for its transfer.
module extended_gcd_bezout #(
  parameter int unsigned OPERAND_BITS = egb_pkg::EGB_OPERAND_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [OPERAND_BITS-2:0] operand_a_i,
  input  logic [OPERAND_BITS-2:0] operand_b_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [OPERAND_BITS-2:0] divisor_o,
  output logic [OPERAND_BITS-1:0] coeff_x_o,
  output logic [OPERAND_BITS-1:0] coeff_y_o
);
  import egb_pkg::*;

  egb_op_e                 op;
  egb_status_t             status;
  logic                    load_ready;
  logic                    out_busy;
  logic                    out_valid_q, out_valid_d;
  logic [OPERAND_BITS-2:0] dp_divisor;
  logic [OPERAND_BITS-1:0] dp_coeff_x, dp_coeff_y;
  logic [OPERAND_BITS-2:0] divisor_q;
  logic [OPERAND_BITS-1:0] coeff_x_q, coeff_y_q;

  // A waiting result blocks an emit only if it is not taken in the same cycle.
  assign out_busy = out_valid_q && out_stall_i;

  egb_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_busy_i  (out_busy),
    .status_i    (status),
    .op_o        (op),
    .load_ready_o(load_ready)
  );

  egb_dp #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op),
    .operand_a_i(operand_a_i),
    .operand_b_i(operand_b_i),
    .status_o   (status),
    .divisor_o  (dp_divisor),
    .coeff_x_o  (dp_coeff_x),
    .coeff_y_o  (dp_coeff_y)
  );

  assign in_stall_o = !load_ready;

  // Output valid: set on emit, cleared by the output transfer.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (op == OP_EMIT) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (op == OP_EMIT) begin
      divisor_q <= dp_divisor;
      coeff_x_q <= dp_coeff_x;
      coeff_y_q <= dp_coeff_y;
    end
  end

  assign out_valid_o = out_valid_q;
  assign divisor_o   = divisor_q;
  assign coeff_x_o   = coeff_x_q;
  assign coeff_y_o   = coeff_y_q;

  // Only one item is in flight: the step after an input transfer takes no input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken twice in a row");

  // A loaded item always starts with the zero test.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == OP_LOAD) |=> (op == OP_INIT))
    else $error("load not followed by test");

  // The last divide cycle hands over to the update step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == OP_DIV && status.div_last) |=> (op == OP_SWAP))
    else $error("divide loop overran");

  // An emit never overwrites a result that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == OP_EMIT) |-> !out_busy)
    else $error("result overwritten");

  // An emitted result is presented in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == OP_EMIT) |=> out_valid_o)
    else $error("emitted result not presented");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the extended GCD block: directed table, then random operands.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned OB = egb_pkg::EGB_OPERAND_BITS;
  localparam logic [OB-2:0] OP_MAX = '1;
  localparam logic [OB-2:0] FIB_46 = 31'd1836311903;
  localparam logic [OB-2:0] FIB_45 = 31'd1134903170;
  localparam int unsigned RANDOM_ITEMS = 348;
  localparam int unsigned DIRECTED_ITEMS = 22;
  localparam int unsigned DRAIN_CYCLES = 4 * (OB + 1);

  // One result of the block.
  typedef struct packed {
    logic [OB-2:0] divisor;
    logic [OB-1:0] coeff_x;
    logic [OB-1:0] coeff_y;
  } gcd_result_t;

  // One row of the directed table; the result is only used when typed is set.
  typedef struct packed {
    logic [OB-2:0] a;
    logic [OB-2:0] b;
    logic          typed;
    gcd_result_t   want;
  } gcd_case_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  logic [OB-2:0] operand_a_i = '0;
  logic [OB-2:0] operand_b_i = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  logic [OB-2:0] divisor_o;
  logic [OB-1:0] coeff_x_o;
  logic [OB-1:0] coeff_y_o;

  gcd_result_t pending_results [$];
  int unsigned mismatches = 0;
  int unsigned sender_idle_pct = 11;
  int unsigned receiver_stall_pct = 58;

  // Extremes, trivial cases, the longest quotient chain and a few plain pairs.
  gcd_case_t directed_cases [0:DIRECTED_ITEMS-1] = '{
    '{31'd0,         31'd0,         1'b1, '{31'd0,  32'd1, 32'd0}},
    '{31'd5,         31'd0,         1'b1, '{31'd5,  32'd1, 32'd0}},
    '{OP_MAX,        31'd0,         1'b1, '{OP_MAX, 32'd1, 32'd0}},
    '{31'd1,         31'd0,         1'b1, '{31'd1,  32'd1, 32'd0}},
    '{31'd0,         31'd1,         1'b1, '{31'd1,  32'd0, 32'd1}},
    '{31'd0,         OP_MAX,        1'b1, '{OP_MAX, 32'd0, 32'd1}},
    '{31'd1,         31'd1,         1'b0, '0},
    '{OP_MAX,        OP_MAX,        1'b0, '0},
    '{OP_MAX,        31'd1,         1'b0, '0},
    '{31'd1,         OP_MAX,        1'b0, '0},
    '{OP_MAX,        OP_MAX - 1'b1, 1'b0, '0},
    '{FIB_46,        FIB_45,        1'b0, '0},
    '{FIB_45,        FIB_46,        1'b0, '0},
    '{31'd240,       31'd46,        1'b0, '0},
    '{31'd12,        31'd18,        1'b0, '0},
    '{31'h4000_0000, 31'h2000_0000, 1'b0, '0},
    '{31'h5555_5555, 31'h2AAA_AAAA, 1'b0, '0},
    '{31'h2AAA_AAAA, 31'h5555_5555, 1'b0, '0},
    '{31'd2147483629, 31'd2147483587, 1'b0, '0},
    '{31'd6,         31'd9,         1'b0, '0},
    '{OP_MAX,        31'h4000_0000, 1'b0, '0},
    '{31'h4000_0000, 31'd3,         1'b0, '0}
  };

  extended_gcd_bezout u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .divisor_o   (divisor_o),
    .coeff_x_o   (coeff_x_o),
    .coeff_y_o   (coeff_y_o)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Iterative Euclid with coefficients kept modulo 2^64, then cut to the port widths.
  function automatic gcd_result_t bezout_of(logic [OB-2:0] a, logic [OB-2:0] b);
    logic [63:0] r0, r1, s0, s1, t0, t1, quot, r_next, s_next, t_next;
    gcd_result_t res;
    r0 = 64'(a);
    r1 = 64'(b);
    s0 = 64'd1;
    s1 = 64'd0;
    t0 = 64'd0;
    t1 = 64'd1;
    while (r1 != 64'd0) begin
      quot   = r0 / r1;
      r_next = r0 - quot * r1;
      s_next = s0 - quot * s1;
      t_next = t0 - quot * t1;
      r0 = r1;
      r1 = r_next;
      s0 = s1;
      s1 = s_next;
      t0 = t1;
      t1 = t_next;
    end
    res.divisor = r0[OB-2:0];
    res.coeff_x = s0[OB-1:0];
    res.coeff_y = t0[OB-1:0];
    return res;
  endfunction

  // Offers one operand pair after a random idle gap and records its result at the transfer.
  task automatic send_operands(logic [OB-2:0] a, logic [OB-2:0] b, gcd_result_t want);
    while ($urandom_range(1, 100) <= sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operand_a_i <= a;
    operand_b_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(want);
  endtask

  // Holds the sender off until every outstanding result is back, then changes idling.
  task automatic drain_and_idle(int unsigned send_pct, int unsigned stall_pct);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    sender_idle_pct    = send_pct;
    receiver_stall_pct = stall_pct;
  endtask

  // Receiver: random stalls and a field-by-field check of every result transfer.
  always @(posedge clk_i) begin
    gcd_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: divisor %0d, x %0d, y %0d", $time, divisor_o,
                 $signed(coeff_x_o), $signed(coeff_y_o));
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (divisor_o !== want.divisor) begin
          $display("%0t: divisor expected %0d, got %0d", $time, want.divisor, divisor_o);
          mismatches++;
        end
        if (coeff_x_o !== want.coeff_x) begin
          $display("%0t: coeff_x expected %0d, got %0d", $time, $signed(want.coeff_x),
                   $signed(coeff_x_o));
          mismatches++;
        end
        if (coeff_y_o !== want.coeff_y) begin
          $display("%0t: coeff_y expected %0d, got %0d", $time, $signed(want.coeff_y),
                   $signed(coeff_y_o));
          mismatches++;
        end
      end
    end
    out_stall_i <= rst_ni && ($urandom_range(1, 100) <= receiver_stall_pct);
  end

  // Stimulus: reset, directed table, then random operand pairs in three idling phases.
  initial begin
    logic [OB-2:0] a, b, common;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_cases[i]) begin
      send_operands(directed_cases[i].a, directed_cases[i].b,
                    directed_cases[i].typed ? directed_cases[i].want
                                            : bezout_of(directed_cases[i].a,
                                                        directed_cases[i].b));
    end

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) drain_and_idle(58, 11);
      if (n == 2 * RANDOM_ITEMS / 3) drain_and_idle(0, 0);
      a = (OB - 1)'($urandom());
      b = (OB - 1)'($urandom());
      case ($urandom_range(0, 15))
        0: b = '0;
        1: a = '0;
        2: begin
          a = (OB - 1)'($urandom_range(0, 255));
          b = (OB - 1)'($urandom_range(0, 255));
        end
        3, 4: begin
          // Shared factor so the divisor is large.
          common = (OB - 1)'($urandom_range(1, 65535));
          a = common * (OB - 1)'($urandom_range(0, 32767));
          b = common * (OB - 1)'($urandom_range(0, 32767));
        end
        5: b = a;
        6: b = a + (OB - 1)'($urandom_range(1, 1000));
        default: ;
      endcase
      send_operands(a, b, bezout_of(a, b));
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #25_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
